// ===== design/vsr_pkg.sv =====
// shared types and constants for the view-change core
`timescale 1ns / 1ps
package vsr_pkg;
  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_SVC  = 3'd1;
  localparam logic [2:0] REQ_DVC  = 3'd2;
  localparam logic [2:0] REQ_SV   = 3'd3;
  localparam logic [2:0] REQ_PREP = 3'd4;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_HB   = 3'd1;
  localparam logic [2:0] KIND_SVC  = 3'd2;
  localparam logic [2:0] KIND_DVC  = 3'd3;
  localparam logic [2:0] KIND_SV   = 3'd4;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_STALE = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_ID    = 1'b1;

  typedef struct packed {
    logic load;
    logic mod_start;
    logic scan_start;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic scan_done;
  } ctl_sts_t;
endpackage

// ===== design/vsr_ctrl.sv =====
// controller state machine sequencing one beat through the datapath
`timescale 1ns / 1ps
module vsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output vsr_pkg::ctl_cmd_t cmd,
  input  vsr_pkg::ctl_sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  assign in_ready  = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r;
    cmd = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.mod_start = cmd.load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

// ===== design/vsr_dp.sv =====
// datapath: view state, tracking tables, modulo unit and result register
`timescale 1ns / 1ps
module vsr_dp #(
  parameter int MAX_REPLICAS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vsr_pkg::ctl_cmd_t cmd,
  output vsr_pkg::ctl_sts_t sts,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [2:0]        in_req_type,
  input  logic [2:0]        in_sender,
  input  logic [31:0]       in_msg_view,
  output logic [2:0]        out_msg_kind,
  output logic [7:0]        out_dest_mask,
  output logic [31:0]       out_out_view,
  output logic [1:0]        out_error_code,
  output logic [31:0]       out_current_view,
  output logic              out_in_change
);
  localparam int NW = (MAX_REPLICAS < 2) ? 1 : $clog2(MAX_REPLICAS);
  localparam int CW = $clog2(MAX_REPLICAS + 1);
  localparam int MW = (CW > 4) ? CW : 4;

  logic [3:0]  total_r;
  logic [2:0]  id_r;
  logic [31:0] view_r, tick_r, heard_r;
  logic        chg_r;

  logic [2:0]  req_r, from_r;
  logic [31:0] mv_r;

  logic        sv_val_r [MAX_REPLICAS];
  logic [31:0] sv_view_r[MAX_REPLICAS];
  logic [MAX_REPLICAS-1:0] sv_seen_r[MAX_REPLICAS];
  logic        dv_val_r [MAX_REPLICAS];
  logic [31:0] dv_view_r[MAX_REPLICAS];
  logic [MAX_REPLICAS-1:0] dv_seen_r[MAX_REPLICAS];

  // group size
  logic [CW-1:0] n;
  logic [MW-1:0] tot_ext;
  always_comb begin
    tot_ext = MW'(total_r);
    if (total_r == 4'd0) n = CW'(1);
    else if (tot_ext > MW'(MAX_REPLICAS)) n = CW'(MAX_REPLICAS);
    else n = CW'(total_r);
  end
  logic [MAX_REPLICAS-1:0] all;
  always_comb begin
    for (int i = 0; i < MAX_REPLICAS; i++) all[i] = (i < int'(n));
  end

  // restoring modulo unit: view_r % n and mv_r % n, one bit a cycle
  logic [5:0]    mcnt_r;
  logic [31:0]   qa_r, qb_r;
  logic [CW:0]   ra_r, rb_r;
  logic          mbusy_r;
  logic [CW:0]   ra_sh, rb_sh;
  assign ra_sh = {ra_r[CW-1:0], qa_r[31]};
  assign rb_sh = {rb_r[CW-1:0], qb_r[31]};
  logic [CW:0]   n_ext;
  assign n_ext = {1'b0, n};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mcnt_r <= '0;
    end else if (cmd.mod_start) begin
      mbusy_r <= 1'b1;
      mcnt_r <= '0;
    end else if (mbusy_r) begin
      mcnt_r <= mcnt_r + 6'd1;
      if (mcnt_r == 6'd31) mbusy_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      qa_r <= view_r;
      qb_r <= in_msg_view;
      ra_r <= '0;
      rb_r <= '0;
    end else if (mbusy_r) begin
      qa_r <= {qa_r[30:0], 1'b0};
      qb_r <= {qb_r[30:0], 1'b0};
      ra_r <= (ra_sh >= n_ext) ? ra_sh - n_ext : ra_sh;
      rb_r <= (rb_sh >= n_ext) ? rb_sh - n_ext : rb_sh;
    end
  end
  assign sts.mod_done = mbusy_r && (mcnt_r == 6'd31);
  logic [NW-1:0] vmod, mvmod;
  assign vmod  = NW'(ra_r);
  assign mvmod = NW'(rb_r);

  // table scan: pass 0 release, pass 1 match, pass 2 free slot
  logic          tab_d;
  logic          tab_op;
  logic [1:0]    pass_r;
  logic [NW:0]   idx_r;
  logic          sbusy_r;
  logic          found_r;
  logic [NW-1:0] slot_r;
  logic [1:0]    tres_r;
  logic          fin_ok_r;
  logic [MAX_REPLICAS-1:0] fb;
  always_comb begin
    fb = '0;
    if (int'(from_r) < MAX_REPLICAS) fb[NW'(from_r)] = 1'b1;
  end
  assign tab_d = (req_r == vsr_pkg::REQ_DVC);
  assign tab_op = (req_r == vsr_pkg::REQ_SVC || req_r == vsr_pkg::REQ_DVC) &&
                  ({1'b0, from_r} < 4'(n));

  logic [NW-1:0]           ix;
  logic                    e_val;
  logic [31:0]             e_view;
  logic [MAX_REPLICAS-1:0] e_seen;
  assign ix = idx_r[NW-1:0];
  always_comb begin
    e_val  = tab_d ? dv_val_r[ix]  : sv_val_r[ix];
    e_view = tab_d ? dv_view_r[ix] : sv_view_r[ix];
    e_seen = tab_d ? dv_seen_r[ix] : sv_seen_r[ix];
  end
  logic idx_last;
  assign idx_last = (idx_r + 1'b1) >= (NW+1)'(n);

  logic                    w_en;
  logic                    w_val;
  logic [31:0]             w_view;
  logic [MAX_REPLICAS-1:0] w_seen;
  logic                    s_step_done;
  always_comb begin
    w_en = 1'b0;
    w_val = e_val;
    w_view = e_view;
    w_seen = e_seen;
    s_step_done = 1'b0;
    if (sbusy_r && tab_op) begin
      case (pass_r)
        2'd0: begin
          if ((e_seen & fb) != '0) begin
            if (!(e_val && e_view == mv_r)) begin
              w_en = 1'b1;
              w_seen = e_seen & ~fb;
              if ((w_seen & all) == '0) w_val = 1'b0;
            end
          end
        end
        2'd1: begin
          if (e_val && e_view == mv_r) begin
            w_en = 1'b1;
            w_seen = e_seen | fb;
          end
        end
        2'd2: begin
          if (!e_val) begin
            w_en = 1'b1;
            w_val = 1'b1;
            w_view = mv_r;
            w_seen = fb;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
      pass_r <= 2'd0;
      idx_r <= '0;
      fin_ok_r <= 1'b0;
    end else begin
      fin_ok_r <= 1'b0;
      if (cmd.scan_start) begin
        sbusy_r <= tab_op;
        fin_ok_r <= !tab_op;
        pass_r <= 2'd0;
        idx_r <= '0;
        tres_r <= vsr_pkg::ERR_FULL;
        slot_r <= '0;
      end else if (sbusy_r) begin
        case (pass_r)
          2'd0: begin
            if ((e_seen & fb) != '0) begin
              if (e_val && e_view == mv_r) begin
                tres_r <= 2'd1;
                slot_r <= ix;
                sbusy_r <= 1'b0;
                fin_ok_r <= 1'b1;
              end else begin
                pass_r <= 2'd1;
                idx_r <= '0;
              end
            end else if (idx_last) begin
              pass_r <= 2'd1;
              idx_r <= '0;
            end else idx_r <= idx_r + 1'b1;
          end
          2'd1: begin
            if (e_val && e_view == mv_r) begin
              tres_r <= ((e_seen & fb) != '0) ? 2'd1 : 2'd0;
              slot_r <= ix;
              sbusy_r <= 1'b0;
              fin_ok_r <= 1'b1;
            end else if (idx_last) begin
              pass_r <= 2'd2;
              idx_r <= '0;
            end else idx_r <= idx_r + 1'b1;
          end
          default: begin
            if (!e_val) begin
              tres_r <= 2'd0;
              slot_r <= ix;
              sbusy_r <= 1'b0;
              fin_ok_r <= 1'b1;
            end else if (idx_last) begin
              tres_r <= vsr_pkg::ERR_FULL;
              sbusy_r <= 1'b0;
              fin_ok_r <= 1'b1;
            end else idx_r <= idx_r + 1'b1;
          end
        endcase
      end
    end
  end
  assign sts.scan_done = fin_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_REPLICAS; i++) begin
        sv_val_r[i] <= 1'b0;
        sv_seen_r[i] <= '0;
        dv_val_r[i] <= 1'b0;
        dv_seen_r[i] <= '0;
      end
    end else if (w_en) begin
      if (tab_d) begin
        dv_val_r[ix] <= w_val;
        dv_view_r[ix] <= w_view;
        dv_seen_r[ix] <= w_seen;
      end else begin
        sv_val_r[ix] <= w_val;
        sv_view_r[ix] <= w_view;
        sv_seen_r[ix] <= w_seen;
      end
    end
  end

  // popcount of the chosen slot
  logic [MAX_REPLICAS-1:0] cs;
  logic [CW-1:0]           cnt;
  always_comb begin
    cs = (tab_d ? dv_seen_r[slot_r] : sv_seen_r[slot_r]) & all;
    cnt = '0;
    for (int i = 0; i < MAX_REPLICAS; i++) cnt = cnt + CW'(cs[i]);
  end

  function automatic logic [7:0] bit8(input logic [31:0] i);
    logic [7:0] b;
    b = '0;
    if (i < 32'd8) b[i[2:0]] = 1'b1;
    return b;
  endfunction

  logic [7:0]  all8;
  assign all8 = 8'(all);
  logic [31:0] tick_inc, d, view_inc;
  assign tick_inc = tick_r + 32'd1;
  assign d = tick_inc - heard_r;
  assign view_inc = view_r + 32'd1;
  logic [CW-1:0] half;
  assign half = n >> 1;
  logic leader;
  assign leader = ({1'b0, id_r} == 4'(vmod));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 4'd3;
      id_r <= 3'd0;
      view_r <= '0;
      chg_r <= 1'b0;
      tick_r <= 32'd1;
      heard_r <= 32'd1;
    end else begin
      if (cfg_we) begin
        if (cfg_index == vsr_pkg::CFG_TOTAL) total_r <= cfg_data[3:0];
        else id_r <= cfg_data[2:0];
      end
      if (cmd.load) begin
        req_r <= in_req_type;
        from_r <= in_sender;
        mv_r <= in_msg_view;
      end
      if (cmd.finish) begin
        out_msg_kind <= vsr_pkg::KIND_NONE;
        out_dest_mask <= '0;
        out_out_view <= '0;
        out_error_code <= vsr_pkg::ERR_OK;
        out_current_view <= view_r;
        out_in_change <= chg_r;
        case (req_r)
          vsr_pkg::REQ_TICK: begin
            if (leader) begin
              out_msg_kind <= vsr_pkg::KIND_HB;
              out_dest_mask <= all8 & ~bit8({29'd0, id_r});
              out_out_view <= view_r;
            end else begin
              tick_r <= tick_inc;
              if (tick_inc > heard_r && d > 32'd2 &&
                  (d < 32'd4 || (d > 32'd5 && d[2:0] == 3'd0))) begin
                out_msg_kind <= vsr_pkg::KIND_SVC;
                out_dest_mask <= all8;
                out_out_view <= view_inc;
              end
            end
          end
          vsr_pkg::REQ_SVC: begin
            if (tab_op) begin
              if (tres_r == vsr_pkg::ERR_FULL) out_error_code <= vsr_pkg::ERR_FULL;
              else if (tres_r == 2'd0) begin
                if (cnt > half) begin
                  chg_r <= 1'b1;
                  view_r <= mv_r;
                  tick_r <= heard_r - 32'd1;
                  out_in_change <= 1'b1;
                  out_current_view <= mv_r;
                  out_msg_kind <= vsr_pkg::KIND_DVC;
                  out_dest_mask <= bit8(32'(mvmod));
                  out_out_view <= mv_r;
                end else if (mv_r == view_inc && tick_r > heard_r &&
                             (tick_r - heard_r) < 32'd3) begin
                  out_msg_kind <= vsr_pkg::KIND_SVC;
                  out_dest_mask <= all8;
                  out_out_view <= view_inc;
                end
              end
            end
          end
          vsr_pkg::REQ_DVC: begin
            if (tab_op) begin
              if (tres_r == vsr_pkg::ERR_FULL) out_error_code <= vsr_pkg::ERR_FULL;
              else if (tres_r == 2'd0 && cnt >= half) begin
                view_r <= mv_r;
                chg_r <= 1'b0;
                out_in_change <= 1'b0;
                out_current_view <= mv_r;
                out_msg_kind <= vsr_pkg::KIND_SV;
                out_dest_mask <= all8 & ~bit8({29'd0, id_r});
                out_out_view <= mv_r;
              end
            end
          end
          vsr_pkg::REQ_SV: begin
            if (view_r <= mv_r) begin
              tick_r <= heard_r;
              view_r <= mv_r;
              chg_r <= 1'b0;
              out_current_view <= mv_r;
              out_in_change <= 1'b0;
            end
          end
          vsr_pkg::REQ_PREP: begin
            if (view_r > mv_r) out_error_code <= vsr_pkg::ERR_STALE;
            else if (view_r < mv_r) begin
              view_r <= mv_r;
              chg_r <= 1'b0;
              out_current_view <= mv_r;
              out_in_change <= 1'b0;
              if ({1'b0, id_r} != 4'(mvmod)) tick_r <= heard_r;
            end else if (!chg_r && !leader) tick_r <= heard_r;
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== design/vsr_view_change_core.sv =====
// top level of the replica view-change engine
`timescale 1ns / 1ps
// One beat in, one decision out. A beat accepted first runs through a bit-serial
// modulo unit (view and message view by group size), then for start and do view
// change beats a scan of the tracking table of up to three passes over the group,
// one slot a cycle; the scan status is then registered and the result committed.
// The next beat is taken only once the controller is idle and the output register
// is empty or being read in that cycle, so a new beat is not taken before the last
// one has finished. Configuration writes are taken at any time and must only come
// while the block is idle.
module vsr_view_change_core #(
  parameter int MAX_REPLICAS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_sender,
  input  logic [31:0] in_msg_view,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_msg_kind,
  output logic [7:0]  out_dest_mask,
  output logic [31:0] out_out_view,
  output logic [1:0]  out_error_code,
  output logic [31:0] out_current_view,
  output logic        out_in_change
);
  vsr_pkg::ctl_cmd_t cmd;
  vsr_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  vsr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  vsr_dp #(.MAX_REPLICAS(MAX_REPLICAS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_req_type(in_req_type), .in_sender(in_sender), .in_msg_view(in_msg_view),
    .out_msg_kind(out_msg_kind), .out_dest_mask(out_dest_mask),
    .out_out_view(out_out_view), .out_error_code(out_error_code),
    .out_current_view(out_current_view), .out_in_change(out_in_change)
  );
endmodule
